### sv/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg: shared types and constants of the double-ended queue engine
// Command and result formats, opcode and status codes, queue sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package dqe_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;

  // Fixed field widths of the ports
  localparam int unsigned OpcodeW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Depths of the command queue and the result queue
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned ResQueueDepth = 2;
  localparam int unsigned ResCountW     = $clog2(ResQueueDepth + 1);

  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_REMOVE     = 3'd6
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_PEEK,
    KIND_REMOVE,
    KIND_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               at_back;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_data;
    status_e            status;
    logic [CountW-1:0]  element_count;
  } res_t;

endpackage

`default_nettype wire

### sv/dqe_fifo.sv
// ----------------------------------------------------------------------------
// dqe_fifo: small register queue
// Holds commands or results between the parts of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire T                data_i,
  input  wire logic            pop_i,
  output T                     data_o,
  output logic                 full_o,
  output logic                 empty_o,
  output logic [CNTW-1:0]      count_o
);

  T                entry_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/dqe_front.sv
// ----------------------------------------------------------------------------
// dqe_front: command intake
// Decodes opcodes into command kinds and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [dqe_pkg::OpcodeW-1:0]   opcode_i,
  input  wire logic signed [dqe_pkg::ValueW-1:0] push_value_i,
  input  wire logic                          cmd_pop_i,
  output logic                               cmd_empty_o,
  output dqe_pkg::cmd_t                      cmd_o
);

  dqe_pkg::cmd_t cmd_in;

  // Classify the opcode: kind plus which end it works on
  always_comb begin
    cmd_in.value   = push_value_i;
    cmd_in.at_back = 1'b0;
    unique case (opcode_i)
      dqe_pkg::OP_PUSH_FRONT: cmd_in.kind = dqe_pkg::KIND_PUSH;
      dqe_pkg::OP_PUSH_BACK: begin
        cmd_in.kind    = dqe_pkg::KIND_PUSH;
        cmd_in.at_back = 1'b1;
      end
      dqe_pkg::OP_POP_FRONT: cmd_in.kind = dqe_pkg::KIND_POP;
      dqe_pkg::OP_POP_BACK: begin
        cmd_in.kind    = dqe_pkg::KIND_POP;
        cmd_in.at_back = 1'b1;
      end
      dqe_pkg::OP_PEEK_FRONT: cmd_in.kind = dqe_pkg::KIND_PEEK;
      dqe_pkg::OP_PEEK_BACK: begin
        cmd_in.kind    = dqe_pkg::KIND_PEEK;
        cmd_in.at_back = 1'b1;
      end
      dqe_pkg::OP_REMOVE: cmd_in.kind = dqe_pkg::KIND_REMOVE;
      default: cmd_in.kind = dqe_pkg::KIND_NOP;
    endcase
  end

  dqe_fifo #(
    .T     (dqe_pkg::cmd_t),
    .DEPTH (dqe_pkg::CmdQueueDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .full_o  (full_o),
    .empty_o (cmd_empty_o),
    .count_o ()
  );

endmodule

`default_nettype wire

### sv/dqe_back.sv
// ----------------------------------------------------------------------------
// dqe_back: command execution
// Ring-buffer element memory, head and count, removal scan and compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_back #(
  parameter int unsigned CAPACITY   = dqe_pkg::CapacityDef,
  parameter int unsigned DATA_WIDTH = dqe_pkg::DataWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_empty_i,
  input  wire dqe_pkg::cmd_t                 cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic [dqe_pkg::ResCountW-1:0] res_count_i,
  output logic                               res_push_o,
  output dqe_pkg::res_t                      res_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MinForRemoval = 3;

  typedef enum logic [1:0] {ST_RUN, ST_SCAN, ST_DECIDE, ST_COPY} state_e;

  state_e                       state_q, state_d;
  logic [IW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;

  logic                         stage_valid_q, stage_valid_d;
  logic                         stage_rd_q, stage_rd_d;
  dqe_pkg::status_e             stage_status_q, stage_status_d;

  logic [CW-1:0]                scan_pos_q, scan_pos_d;
  logic                         chk_vld_q, chk_vld_d;
  logic [CW-1:0]                chk_pos_q, chk_pos_d;
  logic signed [DATA_WIDTH-1:0] max_q, max_d, min_q, min_d;
  logic [CW-1:0]                imax_q, imax_d, imin_q, imin_d;

  logic [CW-1:0]                gap_q, gap_d;
  logic [CW-1:0]                copy_pos_q, copy_pos_d;
  logic                         wr_vld_q, wr_vld_d;
  logic [IW-1:0]                wr_addr_q, wr_addr_d;

  logic [DATA_WIDTH-1:0]        mem_q [CAPACITY];
  logic signed [DATA_WIDTH-1:0] mem_rd_q;
  logic                         mem_we, mem_re;
  logic [IW-1:0]                mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0]        mem_wd;

  logic                         can_start;
  logic [CW-1:0]                lo, hi;

  // Ring position of element pos counted from base; the sum stays below 2*CAPACITY
  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] base, logic [CW-1:0] pos);
    logic [IW:0] sum;
    sum = {1'b0, base} + (IW+1)'(pos);
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign can_start = !cmd_empty_i &&
                     (({1'b0, res_count_i} + (dqe_pkg::ResCountW+1)'(stage_valid_q)) <
                      (dqe_pkg::ResCountW+1)'(dqe_pkg::ResQueueDepth));

  assign lo = (imax_q < imin_q) ? imax_q : imin_q;
  assign hi = (imax_q < imin_q) ? imin_q : imax_q;

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    count_d        = count_q;
    stage_valid_d  = 1'b0;
    stage_rd_d     = 1'b0;
    stage_status_d = dqe_pkg::STATUS_OK;
    scan_pos_d     = scan_pos_q;
    chk_vld_d      = 1'b0;
    chk_pos_d      = chk_pos_q;
    max_d          = max_q;
    min_d          = min_q;
    imax_d         = imax_q;
    imin_d         = imin_q;
    gap_d          = gap_q;
    copy_pos_d     = copy_pos_q;
    wr_vld_d       = 1'b0;
    wr_addr_d      = wr_addr_q;
    cmd_pop_o      = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = wr_addr_q;
    mem_wd         = mem_rd_q;
    mem_re         = 1'b0;
    mem_ra         = head_q;

    unique case (state_q)
      ST_RUN: begin
        if (can_start) begin
          cmd_pop_o     = 1'b1;
          stage_valid_d = 1'b1;
          case (cmd_i.kind)
            dqe_pkg::KIND_PUSH: begin
              if (count_q == CW'(CAPACITY)) begin
                stage_status_d = dqe_pkg::STATUS_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wd  = DATA_WIDTH'(cmd_i.value);
                count_d = count_q + CW'(1);
                if (cmd_i.at_back) begin
                  mem_wa = slot_of(head_q, count_q);
                end else begin
                  head_d = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
                  mem_wa = head_d;
                end
              end
            end
            dqe_pkg::KIND_POP, dqe_pkg::KIND_PEEK: begin
              if (count_q == '0) begin
                stage_status_d = dqe_pkg::STATUS_EMPTY;
              end else begin
                mem_re     = 1'b1;
                stage_rd_d = 1'b1;
                mem_ra     = cmd_i.at_back ? slot_of(head_q, count_q - CW'(1)) : head_q;
                if (cmd_i.kind == dqe_pkg::KIND_POP) begin
                  count_d = count_q - CW'(1);
                  if (!cmd_i.at_back) begin
                    head_d = slot_of(head_q, CW'(1));
                  end
                end
              end
            end
            dqe_pkg::KIND_REMOVE: begin
              // With three or more elements, hold the result back until the scan and compaction finish
              if (count_q >= CW'(MinForRemoval)) begin
                stage_valid_d = 1'b0;
                scan_pos_d    = '0;
                state_d       = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle, fold in the word read the cycle before
        if (scan_pos_q < count_q) begin
          mem_re     = 1'b1;
          mem_ra     = slot_of(head_q, scan_pos_q);
          chk_vld_d  = 1'b1;
          chk_pos_d  = scan_pos_q;
          scan_pos_d = scan_pos_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (chk_pos_q == '0) begin
            max_d  = mem_rd_q;
            min_d  = mem_rd_q;
            imax_d = '0;
            imin_d = '0;
          end else begin
            if (mem_rd_q > max_q) begin
              max_d  = mem_rd_q;
              imax_d = chk_pos_q;
            end
            if (mem_rd_q < min_q) begin
              min_d  = mem_rd_q;
              imin_d = chk_pos_q;
            end
          end
          if (chk_pos_q == count_q - CW'(1)) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        // Nothing lies strictly between equal or adjacent ends
        if ((imax_q == imin_q) || ((hi - lo) < CW'(2))) begin
          stage_valid_d = 1'b1;
          state_d       = ST_RUN;
        end else begin
          gap_d      = hi - lo - CW'(1);
          copy_pos_d = hi;
          state_d    = ST_COPY;
        end
      end

      ST_COPY: begin
        // Move each element from hi onwards down by gap places
        if (copy_pos_q < count_q) begin
          mem_re     = 1'b1;
          mem_ra     = slot_of(head_q, copy_pos_q);
          wr_vld_d   = 1'b1;
          wr_addr_d  = slot_of(head_q, copy_pos_q - gap_q);
          copy_pos_d = copy_pos_q + CW'(1);
        end else if (!wr_vld_q) begin
          count_d       = count_q - gap_q;
          stage_valid_d = 1'b1;
          state_d       = ST_RUN;
        end
        if (wr_vld_q) begin
          mem_we = 1'b1;
          mem_wa = wr_addr_q;
          mem_wd = mem_rd_q;
        end
      end

      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_RUN;
      head_q         <= '0;
      count_q        <= '0;
      stage_valid_q  <= 1'b0;
      stage_rd_q     <= 1'b0;
      stage_status_q <= dqe_pkg::STATUS_OK;
      scan_pos_q     <= '0;
      chk_vld_q      <= 1'b0;
      copy_pos_q     <= '0;
      gap_q          <= '0;
      wr_vld_q       <= 1'b0;
    end else begin
      state_q        <= state_d;
      head_q         <= head_d;
      count_q        <= count_d;
      stage_valid_q  <= stage_valid_d;
      stage_rd_q     <= stage_rd_d;
      stage_status_q <= stage_status_d;
      scan_pos_q     <= scan_pos_d;
      chk_vld_q      <= chk_vld_d;
      copy_pos_q     <= copy_pos_d;
      gap_q          <= gap_d;
      wr_vld_q       <= wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_pos_q <= chk_pos_d;
    max_q     <= max_d;
    min_q     <= min_d;
    imax_q    <= imax_d;
    imin_q    <= imin_d;
    wr_addr_q <= wr_addr_d;
  end

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_ra];
    end
  end

  // Result leaves in the cycle after execution, when the read word is ready
  assign res_push_o = stage_valid_q;

  always_comb begin
    res_o.read_data     = stage_rd_q ? dqe_pkg::ValueW'(mem_rd_q) : '0;
    res_o.status        = stage_status_q;
    res_o.element_count = dqe_pkg::CountW'(count_q);
  end

endmodule

`default_nettype wire

### sv/double_ended_queue_engine.sv
// ----------------------------------------------------------------------------
// double_ended_queue_engine: bounded double-ended queue of signed words
// Push, pop and peek at either end, and removal of the elements between
// the first maximum and the first minimum.
// ----------------------------------------------------------------------------
// A result passes the command queue, the back-end stage and the result queue.
// A command starts only while the two-entry result queue has room for its result.
// A removal reads each element to scan and each moved one again to copy,
// all through the single read port of the element memory.
// Reset: head and count clear at once; the element memory is not cleared,
// since only entries that hold elements are ever read.
`default_nettype none

module double_ended_queue_engine #(
  parameter int unsigned CAPACITY   = dqe_pkg::CapacityDef,
  parameter int unsigned DATA_WIDTH = dqe_pkg::DataWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Command side
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [dqe_pkg::OpcodeW-1:0]       opcode_i,
  input  wire logic signed [dqe_pkg::ValueW-1:0] push_value_i,
  // Result side
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [dqe_pkg::ValueW-1:0]      read_data_o,
  output logic [dqe_pkg::StatusW-1:0]            status_o,
  output logic [dqe_pkg::CountW-1:0]             element_count_o
);

  dqe_pkg::cmd_t                  cmd;
  logic                           cmd_empty, cmd_pop;
  dqe_pkg::res_t                  res_in, res_out;
  logic                           res_push;
  logic [dqe_pkg::ResCountW-1:0]  res_count;

  // Front end: decode and queue each command transfer
  dqe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_empty_o  (cmd_empty),
    .cmd_o        (cmd)
  );

  // Back end: execute against the ring buffer; it only starts a command
  // when the result queue has room for its result
  dqe_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue: parts the back end from a stalled consumer
  dqe_fifo #(
    .T     (dqe_pkg::res_t),
    .DEPTH (dqe_pkg::ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign read_data_o     = res_out.read_data;
  assign status_o        = res_out.status;
  assign element_count_o = res_out.element_count;

endmodule

`default_nettype wire
